// ===== rtl/pnce_pkg.sv =====
// pnce_pkg: constants, result type and ones' complement add for the
// packet nested checksum engine; no dependencies
package pnce_pkg;

	localparam logic [7:0] INNER_BIAS     = 8'h33;
	localparam logic [7:0] INNER_MIN_LEN  = 8'd19;
	localparam logic [7:0] LE_FRAME_TYPE  = 8'd2;

	localparam logic [8:0] HEAD_BYTES      = 9'd9;
	localparam logic [8:0] OFF_RSVD_LO     = 9'd10;
	localparam logic [8:0] OFF_RSVD_HI     = 9'd11;
	localparam logic [8:0] OFF_FRAME_TYPE  = 9'd12;
	localparam logic [8:0] OFF_INNER_FIRST = 9'd13;
	localparam logic [8:0] OFF_PCOUNT_LE   = 9'd15;
	localparam logic [8:0] OFF_PCOUNT      = 9'd16;
	localparam logic [8:0] PAYLOAD_START   = 9'd17;
	localparam logic [8:0] OFFSET_MAX      = 9'd511;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_SHORT   = 2'd1;
	localparam logic [1:0] STATUS_OVERRUN = 2'd2;

	typedef struct packed {
		logic [15:0] outer_checksum;
		logic [7:0]  inner_checksum;
		logic        inner_present;
		logic [1:0]  status;
	} pnce_result_t;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ===== rtl/pnce_datapath.sv =====
// pnce_datapath: per-packet state and one-beat update of the inner and
// outer checksums; uses pnce_pkg
module pnce_datapath import pnce_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   data_byte,
	input  logic         end_of_packet,
	output pnce_result_t result
);

	logic [8:0]  off_q;
	logic [7:0]  len_q;
	logic [7:0]  ftype_q;
	logic [7:0]  pcount_q;
	logic [7:0]  isum_q;
	logic [15:0] acc_q;
	logic        ovr_q;
	logic        known_q;
	logic        placed_q;
	logic [7:0]  ival_q;
	logic [15:0] psum_q [0:8];

	logic        is_head;
	logic        is_len;
	logic        len_big;
	logic [8:0]  len_m2;
	logic [7:0]  ftype_new;
	logic [7:0]  pcount_new;
	logic        hdr_inner;
	logic        payload_inner;
	logic [7:0]  isum_new;
	logic        ovr_new;
	logic        covered;
	logic        place;
	logic [7:0]  ival_calc;
	logic [7:0]  b_eff;
	logic [15:0] word_raw;
	logic [15:0] word_eff;
	logic [15:0] head_base;
	logic [15:0] acc_new;
	logic        placed_new;
	logic [7:0]  ival_new;
	logic        known_new;
	logic [7:0]  len_new;
	logic        is_short;
	logic [8:0]  off_inc;

	always_comb begin
		is_head   = off_q < HEAD_BYTES;
		is_len    = off_q == HEAD_BYTES;
		len_big   = len_q > INNER_MIN_LEN;
		len_m2    = {1'b0, len_q} - 9'd2;
		ftype_new = (off_q == OFF_FRAME_TYPE) ? data_byte : ftype_q;

		pcount_new = pcount_q;
		if (off_q == OFF_PCOUNT_LE && ftype_q == LE_FRAME_TYPE) begin
			pcount_new = data_byte;
		end
		if (off_q == OFF_PCOUNT && ftype_q != LE_FRAME_TYPE) begin
			pcount_new = data_byte;
		end

		hdr_inner     = (off_q >= OFF_INNER_FIRST) && (off_q <= OFF_PCOUNT);
		payload_inner = (off_q >= PAYLOAD_START) && len_big
			&& ((off_q - PAYLOAD_START) < {1'b0, pcount_q}) && (off_q < len_m2);
		isum_new = (hdr_inner || payload_inner) ? isum_q + data_byte : isum_q;

		ovr_new = ovr_q || ((off_q == OFF_PCOUNT) && len_big
			&& (pcount_new > (len_q - INNER_MIN_LEN)));

		// bytes from offset 10 on
		covered   = off_q < {1'b0, len_q};
		place     = (len_q >= INNER_MIN_LEN) && (off_q == len_m2);
		ival_calc = ~isum_q + INNER_BIAS;
		if (place) begin
			b_eff = ival_calc;
		end else if (off_q == OFF_RSVD_LO || off_q == OFF_RSVD_HI) begin
			b_eff = 8'd0;
		end else begin
			b_eff = data_byte;
		end
		word_raw = off_q[0] ? {data_byte, 8'h00} : {8'h00, data_byte};
		word_eff = off_q[0] ? {b_eff, 8'h00} : {8'h00, b_eff};

		// length byte: keep only head bytes below the covered length
		head_base = ({1'b0, data_byte} >= HEAD_BYTES) ? acc_q : psum_q[data_byte[3:0]];

		placed_new = placed_q;
		ival_new   = ival_q;
		if (is_head) begin
			acc_new = ones_add(acc_q, word_raw);
		end else if (is_len) begin
			acc_new = ({1'b0, data_byte} > HEAD_BYTES)
				? ones_add(head_base, {data_byte, 8'h00}) : head_base;
		end else begin
			acc_new = covered ? ones_add(acc_q, word_eff) : acc_q;
			if (covered && place) begin
				placed_new = 1'b1;
				ival_new   = ival_calc;
			end
		end

		known_new = known_q || is_len;
		len_new   = is_len ? data_byte : len_q;
		is_short  = !known_new || (({1'b0, off_q} + 10'd1) < {2'b00, len_new});
		off_inc   = (off_q < OFFSET_MAX) ? off_q + 9'd1 : off_q;

		result.outer_checksum = ~acc_new;
		result.inner_checksum = placed_new ? ival_new : 8'd0;
		result.inner_present  = placed_new;
		if (is_short) begin
			result.status = STATUS_SHORT;
		end else if (ovr_new) begin
			result.status = STATUS_OVERRUN;
		end else begin
			result.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			len_q    <= '0;
			ftype_q  <= '0;
			pcount_q <= '0;
			isum_q   <= '0;
			acc_q    <= '0;
			ovr_q    <= 1'b0;
			known_q  <= 1'b0;
			placed_q <= 1'b0;
			ival_q   <= '0;
		end else if (step) begin
			if (end_of_packet) begin
				off_q    <= '0;
				len_q    <= '0;
				ftype_q  <= '0;
				pcount_q <= '0;
				isum_q   <= '0;
				acc_q    <= '0;
				ovr_q    <= 1'b0;
				known_q  <= 1'b0;
				placed_q <= 1'b0;
				ival_q   <= '0;
			end else begin
				off_q    <= off_inc;
				len_q    <= len_new;
				ftype_q  <= ftype_new;
				pcount_q <= pcount_new;
				isum_q   <= isum_new;
				acc_q    <= acc_new;
				ovr_q    <= ovr_new;
				known_q  <= known_new;
				placed_q <= placed_new;
				ival_q   <= ival_new;
			end
		end
	end

	// running sum before each head byte
	always_ff @(posedge clk) begin
		if (step && is_head) begin
			psum_q[off_q[3:0]] <= acc_q;
		end
	end

endmodule

// ===== rtl/packet_nested_checksum_engine_unit.sv =====
// packet_nested_checksum_engine_unit: top level with input stage and result
// register; uses pnce_pkg and pnce_datapath
// a packet's last beat passes the input stage register, then its result is loaded into the result register
// throughput: one beat per cycle; a beat stalls only behind an untaken result
// the per-beat sum update is one 16-bit end-around-carry add in the datapath stage
// reset: arst_n clears the stage valids and all packet state but the head sums in psum_q; state also clears per packet
module packet_nested_checksum_engine_unit import pnce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] outer_checksum,
	output logic [7:0]  inner_checksum,
	output logic        inner_present,
	output logic [1:0]  status
);

	logic         v_s1;
	logic [7:0]   byte_s1;
	logic         eop_s1;
	logic         adv;
	logic         out_valid_q;
	pnce_result_t res_q;
	pnce_result_t res_next;

	assign adv      = v_s1 && (!eop_s1 || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eop_s1  <= end_of_packet;
		end
	end

	pnce_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.data_byte     (byte_s1),
		.end_of_packet (eop_s1),
		.result        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && eop_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eop_s1) begin
			res_q <= res_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign outer_checksum = res_q.outer_checksum;
	assign inner_checksum = res_q.inner_checksum;
	assign inner_present  = res_q.inner_present;
	assign status         = res_q.status;

`ifndef SYNTHESIS
	a_stall_only_behind_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && v_s1 && eop_s1))
		else $error("input stalled without a pending result");

	a_overrun_has_inner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_OVERRUN) |-> inner_present)
		else $error("overrun reported without placed inner checksum");

	a_absent_inner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !inner_present) |-> (inner_checksum == 8'd0))
		else $error("inner checksum nonzero while not present");
`endif

endmodule

// ===== tb/pnce_checksum_checker.sv =====
`timescale 1ns / 100ps
// pnce_checksum_checker: watches both channels of the checksum engine, predicts the
// outer and inner checksums and status per packet, and compares each result beat
// depends on pnce_pkg for constants and the result struct
module pnce_checksum_checker import pnce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] outer_checksum,
	input  logic [7:0]  inner_checksum,
	input  logic        inner_present,
	input  logic [1:0]  status,
	output int          results_due,
	output int          mismatch_count
);

	logic [8:0]   byte_pos;
	logic [7:0]   cov_len;
	logic [7:0]   ftype;
	logic [7:0]   pay_cnt;
	logic [7:0]   inner_acc;
	logic [16:0]  outer_acc;
	logic [7:0]   low_hold;
	logic         overrun;
	logic         len_known;
	logic         low_valid;
	logic         inner_done;
	logic [7:0]   inner_val;
	logic [7:0]   head_mem [0:HEAD_BYTES-1];
	pnce_result_t checksums_due [$];
	pnce_result_t want;
	int           errs;

	task automatic clear_packet_state();
		int i;
		byte_pos   = '0;
		cov_len    = '0;
		ftype      = '0;
		pay_cnt    = '0;
		inner_acc  = '0;
		outer_acc  = '0;
		low_hold   = '0;
		overrun    = 1'b0;
		len_known  = 1'b0;
		low_valid  = 1'b0;
		inner_done = 1'b0;
		inner_val  = '0;
		for (i = 0; i < HEAD_BYTES; i++)
			head_mem[i] = '0;
	endtask

	function automatic logic [16:0] end_around_add(input logic [16:0] s, input logic [16:0] w);
		logic [17:0] t;
		t = {1'b0, s} + {1'b0, w};
		if (t[17:16] != 2'd0)
			t = {2'd0, t[15:0]} + {16'd0, t[17:16]};
		return t[16:0];
	endfunction

	// add one covered byte to the running word sum
	task automatic add_covered_byte(input int off, input logic [7:0] b, input int lim);
		logic [7:0] v;
		if (off >= lim)
			return;
		v = b;
		if (off == OFF_RSVD_LO || off == OFF_RSVD_HI)
			v = 8'd0;
		if (len_known && cov_len >= INNER_MIN_LEN && off == int'(cov_len) - 2) begin
			inner_val  = ~inner_acc + INNER_BIAS;
			inner_done = 1'b1;
			v = inner_val;
		end
		if (off[0] == 1'b0) begin
			if (off + 1 == lim) begin
				outer_acc = end_around_add(outer_acc, {9'd0, v});
			end else begin
				low_hold  = v;
				low_valid = 1'b1;
			end
		end else begin
			outer_acc = end_around_add(outer_acc, {1'b0, v, low_hold});
			low_hold  = '0;
			low_valid = 1'b0;
		end
	endtask

	task automatic fold_packet_byte(input logic [7:0] b, input logic last);
		int off;
		int len;
		int i;
		logic [16:0] s;
		logic short_pkt;
		pnce_result_t r;
		off = int'(byte_pos);
		len = int'(cov_len);
		if (off < HEAD_BYTES) begin
			head_mem[off] = b;
		end else if (off == HEAD_BYTES) begin
			cov_len   = b;
			len_known = 1'b1;
			for (i = 0; i < HEAD_BYTES; i++)
				add_covered_byte(i, head_mem[i], int'(b));
			add_covered_byte(off, b, int'(b));
		end else begin
			if (off == OFF_FRAME_TYPE)
				ftype = b;
			if (off >= OFF_INNER_FIRST && off <= OFF_PCOUNT)
				inner_acc = inner_acc + b;
			if (off == OFF_PCOUNT_LE && ftype == LE_FRAME_TYPE)
				pay_cnt = b;
			if (off == OFF_PCOUNT && ftype != LE_FRAME_TYPE)
				pay_cnt = b;
			if (off == OFF_PCOUNT && len > INNER_MIN_LEN &&
			    int'(pay_cnt) > len - int'(INNER_MIN_LEN))
				overrun = 1'b1;
			if (off >= PAYLOAD_START && len > INNER_MIN_LEN &&
			    off - int'(PAYLOAD_START) < int'(pay_cnt) && off < len - 2)
				inner_acc = inner_acc + b;
			add_covered_byte(off, b, len);
		end

		if (!last) begin
			if (byte_pos < OFFSET_MAX)
				byte_pos = byte_pos + 9'd1;
			return;
		end

		if (!len_known) begin
			// length never arrived: every received head byte counts
			for (i = 0; i <= off && i < HEAD_BYTES; i++)
				add_covered_byte(i, head_mem[i], 256);
			short_pkt = 1'b1;
		end else begin
			short_pkt = (off + 1 < int'(cov_len));
		end

		s = outer_acc;
		if (low_valid)
			s = end_around_add(s, {9'd0, low_hold});
		s = end_around_add(s, 17'd0);

		r.outer_checksum = ~s[15:0];
		r.inner_checksum = inner_done ? inner_val : 8'd0;
		r.inner_present  = inner_done;
		r.status         = short_pkt ? STATUS_SHORT : (overrun ? STATUS_OVERRUN : STATUS_OK);
		checksums_due.push_back(r);
		clear_packet_state();
	endtask

	task automatic compare_field(input string name, input logic [15:0] exp_v,
	                             input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			errs++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_packet_state();
			checksums_due.delete();
			errs = 0;
			results_due    <= 0;
			mismatch_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (checksums_due.size() == 0) begin
					errs++;
					$display("%0t: result beat with none due, expected none, got outer %0h",
					         $time, outer_checksum);
				end else begin
					want = checksums_due.pop_front();
					compare_field("outer_checksum", want.outer_checksum, outer_checksum);
					compare_field("inner_checksum", {8'd0, want.inner_checksum},
					              {8'd0, inner_checksum});
					compare_field("inner_present", {15'd0, want.inner_present},
					              {15'd0, inner_present});
					compare_field("status", {14'd0, want.status}, {14'd0, status});
				end
			end
			if (in_valid && in_ready)
				fold_packet_byte(data_byte, end_of_packet);
			results_due    <= checksums_due.size();
			mismatch_count <= errs;
		end
	end

endmodule

// ===== tb/tb_packet_nested_checksum_engine_unit.sv =====
`timescale 1ns / 100ps
// tb_packet_nested_checksum_engine_unit: drives directed and random packet bytes into
// the checksum engine under several idle and stall mixes and gives the verdict
// depends on pnce_pkg, packet_nested_checksum_engine_unit and pnce_checksum_checker
module tb_packet_nested_checksum_engine_unit;
	import pnce_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RX_HOLD_CYCLES  = 400;
	localparam int PHASE_BEATS     = 300;
	localparam int PHASE_MIN_BEATS = 150;
	localparam int LONG_PKT_BYTES  = 530;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        end_of_packet = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] outer_checksum;
	logic [7:0]  inner_checksum;
	logic        inner_present;
	logic [1:0]  status;

	int          results_due;
	int          mismatch_count;
	int          cycle_count = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	logic        hold_req = 1'b0;
	int          sent = 0;
	logic [7:0]  pkt [$];

	int          idle_by_phase [4] = '{0, 71, 0, 8};
	int          stall_by_phase [4] = '{0, 0, 71, 8};

	packet_nested_checksum_engine_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_packet  (end_of_packet),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.outer_checksum (outer_checksum),
		.inner_checksum (inner_checksum),
		.inner_present  (inner_present),
		.status         (status)
	);

	pnce_checksum_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_packet  (end_of_packet),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.outer_checksum (outer_checksum),
		.inner_checksum (inner_checksum),
		.inner_present  (inner_present),
		.status         (status),
		.results_due    (results_due),
		.mismatch_count (mismatch_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[packet_nested_checksum_engine_unit] ERROR");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off when asked
	initial begin
		int n;
		logic held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				for (n = 0; n < RX_HOLD_CYCLES; n++) begin
					out_ready <= 1'b0;
					@(posedge clk);
				end
			end
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic put_beat(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		end_of_packet <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_packet();
		int i;
		for (i = 0; i < pkt.size(); i++)
			put_beat(pkt[i], i == pkt.size() - 1);
		sent += pkt.size();
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	task automatic make_packet();
		int kind;
		int len;
		int full;
		int total;
		int cnt;
		int i;
		logic [7:0] ft;
		logic [7:0] b;
		pkt.delete();
		kind = $urandom_range(99);
		if (kind < 8) begin
			// noise
			total = $urandom_range(30, 1);
			repeat (total) pkt.push_back(8'($urandom_range(255)));
			return;
		end
		if (kind < 20)
			len = $urandom_range(18, 0);
		else if (kind < 32)
			len = INNER_MIN_LEN;
		else if (kind < 92)
			len = $urandom_range(40, 20);
		else if (kind < 97)
			len = $urandom_range(254, 41);
		else
			len = 255;

		ft = $urandom_range(1) ? LE_FRAME_TYPE : 8'($urandom_range(255));
		if (len <= INNER_MIN_LEN)
			cnt = $urandom_range(255);
		else begin
			case ($urandom_range(5))
				0: cnt = $urandom_range(255, len - INNER_MIN_LEN + 1);
				1: cnt = len - INNER_MIN_LEN + 1;
				2: cnt = len - INNER_MIN_LEN;
				default: cnt = $urandom_range(len - INNER_MIN_LEN, 0);
			endcase
		end

		full = (len <= HEAD_BYTES) ? HEAD_BYTES + 1 : len;
		case ($urandom_range(9))
			0: total = $urandom_range(full - 1, 1);
			1: total = full - 1;
			2: total = full + $urandom_range(6, 1);
			default: total = full;
		endcase

		for (i = 0; i < total; i++) begin
			b = 8'($urandom_range(255));
			if (i == HEAD_BYTES)
				b = 8'(len);
			if (i == OFF_FRAME_TYPE)
				b = ft;
			if (i == OFF_PCOUNT_LE && ft == LE_FRAME_TYPE)
				b = 8'(cnt);
			if (i == OFF_PCOUNT && ft != LE_FRAME_TYPE)
				b = 8'(cnt);
			pkt.push_back(b);
		end
	endtask

	initial begin
		int phase;
		int npkt;
		int phase_end;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-beat packets, length unknown
		pkt = '{8'hFF};
		send_packet();
		pkt = '{8'h00};
		send_packet();
		// head all ones with length 10, then head all zeros with length 0
		pkt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd10};
		send_packet();
		pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'hFF};
		send_packet();
		wait_results();

		npkt = 0;
		for (phase = 0; phase < 4; phase++) begin
			tx_idle_pct = idle_by_phase[phase];
			rx_stall_pct <= stall_by_phase[phase];
			if (phase == 0)
				hold_req <= 1'b1;
			// every phase gets a fair share even after the long packet
			phase_end = (phase + 1) * PHASE_BEATS;
			if (phase_end < sent + PHASE_MIN_BEATS)
				phase_end = sent + PHASE_MIN_BEATS;
			while (sent < phase_end) begin
				make_packet();
				// one packet runs past the offset counter range
				if (npkt == 5)
					while (pkt.size() < LONG_PKT_BYTES)
						pkt.push_back(8'($urandom_range(255)));
				send_packet();
				npkt++;
			end
			wait_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("[packet_nested_checksum_engine_unit] OK");
		else
			$display("[packet_nested_checksum_engine_unit] ERROR");
		$finish;
	end

endmodule
